@@ sv/gda_pkg.sv @@
// Package for the Gregorian date adder: widths, codes, constants and month length.
package gda_pkg;

	localparam int YEAR_BITS = 15;
	localparam int YEAR_W    = 15;
	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int COUNT_W   = 15;

	localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'((33'd1 << YEAR_BITS) - 33'd1);

	// floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for y < 91180
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(83887);
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam int Q25_W       = PROD_W - RECIP_SHIFT;
	localparam int MOD25_W     = 5;
	localparam logic [MOD25_W-1:0] MOD25_LAST = MOD25_W'(24);

	localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
	localparam logic [DAY_W-1:0]   DAY_LAST   = DAY_W'(31);
	localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);

	typedef enum logic [1:0] {
		CMD_DAYS   = 2'd0,
		CMD_MONTHS = 2'd1,
		CMD_YEARS  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_DATE = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_REM,
		S_DAY,
		S_MON,
		S_DONE
	} state_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2: begin
				len = leap ? DAY_W'(29) : DAY_W'(28);
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = DAY_W'(30);
			end
			default: begin
				len = DAY_W'(31);
			end
		endcase
		return len;
	endfunction

endpackage

@@ sv/gregorian_date_adder_unit.sv @@
// Gregorian date adder: advances a date by a count of days, months or years.
//
// channel | signals                                          | direction
// in      | in_valid, in_ready, cmd, day_in, month_in,       | beat into block
//         | year_in, count                                   |
// out     | out_valid, out_ready, day_out, month_out,        | beat out of block
//         | year_out, status                                 |
//
// Days: a multiply (S_MUL) and a remainder step (S_REM) give the year mod 25, then one step per day.
// Months: one step per month. Years and bad dates go straight to the done state.
// One stepping sequencer; the block takes no new beat while it works.
// A finished result waits in the output register while the next beat is taken.
// arst_n clears the sequencer and the output valid.
module gregorian_date_adder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      cmd,
	input  logic [gda_pkg::DAY_W-1:0]       day_in,
	input  logic [gda_pkg::MONTH_W-1:0]     month_in,
	input  logic [gda_pkg::YEAR_W-1:0]      year_in,
	input  logic [gda_pkg::COUNT_W-1:0]     count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gda_pkg::DAY_W-1:0]       day_out,
	output logic [gda_pkg::MONTH_W-1:0]     month_out,
	output logic [gda_pkg::YEAR_W-1:0]      year_out,
	output logic [1:0]                      status
);

	gda_pkg::state_t state_q, state_nxt;

	logic [gda_pkg::DAY_W-1:0]   d_q;
	logic [gda_pkg::MONTH_W-1:0] m_q;
	logic [gda_pkg::YEAR_W-1:0]  y_q;
	logic [gda_pkg::COUNT_W-1:0] cnt_q;
	logic [1:0]                  st_q;
	logic [gda_pkg::Q25_W-1:0]   q25_q;
	logic [gda_pkg::MOD25_W-1:0] y25_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        bad_date;
	logic [gda_pkg::YEAR_W-1:0]  y_in_m;
	logic [gda_pkg::YEAR_W:0]    y_sum;
	logic [gda_pkg::Q25_W-1:0]   prod;
	logic [gda_pkg::MOD25_W-1:0] rem25;
	logic                        leap;
	logic [gda_pkg::DAY_W-1:0]   mlen;
	logic                        day_wrap;
	logic                        year_end;
	logic                        out_load;

	assign accept   = in_valid && in_ready;
	assign y_in_m   = year_in & gda_pkg::YEAR_MAX;
	assign bad_date = (month_in == '0) || (month_in > gda_pkg::MONTH_DEC) || (day_in == '0);
	assign y_sum    = {1'b0, y_in_m} + {1'b0, count};
	assign prod     = gda_pkg::Q25_W'((gda_pkg::PROD_W'(y_q)
		* gda_pkg::PROD_W'(gda_pkg::RECIP_25)) >> gda_pkg::RECIP_SHIFT);
	assign rem25    = gda_pkg::MOD25_W'(y_q - gda_pkg::YEAR_W'(q25_q) * gda_pkg::YEAR_W'(25));
	assign leap     = (y_q[1:0] == 2'b00) && ((y25_q != '0) || (y_q[3:0] == 4'b0000));
	assign mlen     = gda_pkg::month_len(m_q, leap);
	assign day_wrap = d_q >= mlen;
	assign year_end = (m_q == gda_pkg::MONTH_DEC) && (y_q >= gda_pkg::YEAR_MAX);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gda_pkg::S_IDLE: begin
				if (accept) begin
					if (bad_date) begin
						state_nxt = gda_pkg::S_DONE;
					end else if (cmd == gda_pkg::CMD_DAYS) begin
						state_nxt = gda_pkg::S_MUL;
					end else if (cmd == gda_pkg::CMD_MONTHS) begin
						state_nxt = gda_pkg::S_MON;
					end else begin
						state_nxt = gda_pkg::S_DONE;
					end
				end
			end
			gda_pkg::S_MUL: begin
				state_nxt = gda_pkg::S_REM;
			end
			gda_pkg::S_REM: begin
				state_nxt = gda_pkg::S_DAY;
			end
			gda_pkg::S_DAY: begin
				if (cnt_q == '0 || (day_wrap && year_end)) begin
					state_nxt = gda_pkg::S_DONE;
				end
			end
			gda_pkg::S_MON: begin
				if (cnt_q == '0 || year_end) begin
					state_nxt = gda_pkg::S_DONE;
				end
			end
			gda_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = gda_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = gda_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == gda_pkg::S_IDLE);
		out_load = (state_q == gda_pkg::S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gda_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gda_pkg::S_IDLE: begin
				if (accept) begin
					d_q   <= day_in;
					m_q   <= month_in;
					cnt_q <= count;
					if (bad_date) begin
						y_q  <= y_in_m;
						st_q <= gda_pkg::STAT_BAD_DATE;
					end else if (cmd == gda_pkg::CMD_YEARS
						&& y_sum > {1'b0, gda_pkg::YEAR_MAX}) begin
						y_q  <= gda_pkg::YEAR_MAX;
						st_q <= gda_pkg::STAT_OVERFLOW;
					end else if (cmd == gda_pkg::CMD_YEARS) begin
						y_q  <= y_sum[gda_pkg::YEAR_W-1:0];
						st_q <= gda_pkg::STAT_OK;
					end else begin
						y_q  <= y_in_m;
						st_q <= gda_pkg::STAT_OK;
					end
				end
			end
			gda_pkg::S_MUL: begin
				q25_q <= prod;
			end
			gda_pkg::S_REM: begin
				y25_q <= rem25;
			end
			gda_pkg::S_DAY: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (!day_wrap) begin
						d_q <= d_q + 1'b1;
					end else if (year_end) begin
						d_q  <= gda_pkg::DAY_LAST;
						st_q <= gda_pkg::STAT_OVERFLOW;
					end else if (m_q == gda_pkg::MONTH_DEC) begin
						d_q   <= gda_pkg::DAY_FIRST;
						m_q   <= gda_pkg::MONTH_JAN;
						y_q   <= y_q + 1'b1;
						y25_q <= (y25_q == gda_pkg::MOD25_LAST) ? '0 : y25_q + 1'b1;
					end else begin
						d_q <= gda_pkg::DAY_FIRST;
						m_q <= m_q + 1'b1;
					end
				end
			end
			gda_pkg::S_MON: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (year_end) begin
						st_q <= gda_pkg::STAT_OVERFLOW;
					end else if (m_q == gda_pkg::MONTH_DEC) begin
						m_q <= gda_pkg::MONTH_JAN;
						y_q <= y_q + 1'b1;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			day_out   <= d_q;
			month_out <= m_q;
			year_out  <= y_q;
			status    <= st_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/gda_checker.sv @@
// Port-level checks for the Gregorian date adder, bound to the top level.
module gda_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gda_pkg::DAY_W-1:0]   day_out,
	input logic [gda_pkg::MONTH_W-1:0] month_out,
	input logic [gda_pkg::YEAR_W-1:0]  year_out,
	input logic [1:0]                  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(day_out) && $stable(month_out)
			&& $stable(year_out) && $stable(status))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after accepting a beat");

	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gda_pkg::STAT_OVERFLOW |-> year_out == gda_pkg::YEAR_MAX)
		else $error("overflow without saturated year");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gda_pkg::STAT_OK |-> month_out != '0
			&& month_out <= gda_pkg::MONTH_DEC && day_out != '0)
		else $error("ok status with invalid date");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == gda_pkg::STAT_OK || status == gda_pkg::STAT_BAD_DATE
			|| status == gda_pkg::STAT_OVERFLOW)
		else $error("unused status code");

endmodule

bind gregorian_date_adder_unit gda_checker u_gda_checker (.*);

@@ bench/gregorian_date_adder_unit_test.sv @@
// Testbench for gregorian_date_adder_unit: random and corner date adds checked against a predictor.
`timescale 1ns / 100ps

module gregorian_date_adder_unit_test;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int unsigned MONTHS_PER_YEAR = 12;
	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned HOLD_AT = 600;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned TAIL_CYCLES = 40;

	typedef struct {
		logic [1:0]                  cmd;
		logic [gda_pkg::DAY_W-1:0]   day;
		logic [gda_pkg::MONTH_W-1:0] month;
		logic [gda_pkg::YEAR_W-1:0]  year;
		logic [gda_pkg::COUNT_W-1:0] count;
	} date_req_t;

	typedef struct {
		logic [gda_pkg::DAY_W-1:0]   day;
		logic [gda_pkg::MONTH_W-1:0] month;
		logic [gda_pkg::YEAR_W-1:0]  year;
		gda_pkg::status_t            status;
	} date_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [gda_pkg::DAY_W-1:0] day_in = '0;
	logic [gda_pkg::MONTH_W-1:0] month_in = '0;
	logic [gda_pkg::YEAR_W-1:0] year_in = '0;
	logic [gda_pkg::COUNT_W-1:0] count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [gda_pkg::DAY_W-1:0] day_out;
	logic [gda_pkg::MONTH_W-1:0] month_out;
	logic [gda_pkg::YEAR_W-1:0] year_out;
	logic [1:0] status;

	date_req_t pending_reqs[$];
	date_res_t expected_dates[$];
	date_req_t cur_req;
	int unsigned err_count = 0;
	int unsigned beats_out = 0;
	int unsigned total_items = 0;
	int unsigned hold_left = 0;
	bit hold_done = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	bit send_burst = 0;
	bit recv_burst = 0;
	longint unsigned work_budget = 0;
	longint unsigned cycle_limit = 64'd100_000_000;
	longint unsigned cycles = 0;
	int unsigned cmd_beats[4] = '{0, 0, 0, 0};
	int unsigned bad_dates = 0;
	int unsigned overflows = 0;

	gregorian_date_adder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.day_in    (day_in),
		.month_in  (month_in),
		.year_in   (year_in),
		.count     (count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.day_out   (day_out),
		.month_out (month_out),
		.year_out  (year_out),
		.status    (status)
	);

	always #6 clk = ~clk;

	function automatic bit leap_year(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		case (m)
			2: begin
				return leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	function automatic date_res_t advance_date(date_req_t r);
		date_res_t res;
		int unsigned d, m, y, left, total;
		d = r.day;
		m = r.month;
		y = r.year;
		left = r.count;
		res.status = gda_pkg::STAT_OK;
		if (m < gda_pkg::MONTH_JAN || m > gda_pkg::MONTH_DEC || d == 0) begin
			res.status = gda_pkg::STAT_BAD_DATE;
		end else if (r.cmd == gda_pkg::CMD_DAYS) begin
			while (left != 0 && res.status == gda_pkg::STAT_OK) begin
				left--;
				if (d < days_in_month(m, y)) begin
					d++;
				end else if (m != gda_pkg::MONTH_DEC) begin
					d = gda_pkg::DAY_FIRST;
					m++;
				end else if (y >= gda_pkg::YEAR_MAX) begin
					d = gda_pkg::DAY_LAST;
					res.status = gda_pkg::STAT_OVERFLOW;
				end else begin
					d = gda_pkg::DAY_FIRST;
					m = gda_pkg::MONTH_JAN;
					y++;
				end
			end
		end else if (r.cmd == gda_pkg::CMD_MONTHS) begin
			total = m - 1 + r.count;
			if (y + total / MONTHS_PER_YEAR > gda_pkg::YEAR_MAX) begin
				y = gda_pkg::YEAR_MAX;
				m = gda_pkg::MONTH_DEC;
				res.status = gda_pkg::STAT_OVERFLOW;
			end else begin
				y = y + total / MONTHS_PER_YEAR;
				m = total % MONTHS_PER_YEAR + 1;
			end
		end else if (r.cmd == gda_pkg::CMD_YEARS) begin
			if (y + r.count > gda_pkg::YEAR_MAX) begin
				y = gda_pkg::YEAR_MAX;
				res.status = gda_pkg::STAT_OVERFLOW;
			end else begin
				y = y + r.count;
			end
		end
		res.day = gda_pkg::DAY_W'(d);
		res.month = gda_pkg::MONTH_W'(m);
		res.year = gda_pkg::YEAR_W'(y);
		return res;
	endfunction

	task automatic queue_req(logic [1:0] c, int unsigned d, int unsigned m, int unsigned y,
		int unsigned n);
		date_req_t r;
		r.cmd = c;
		r.day = gda_pkg::DAY_W'(d);
		r.month = gda_pkg::MONTH_W'(m);
		r.year = gda_pkg::YEAR_W'(y);
		r.count = gda_pkg::COUNT_W'(n);
		pending_reqs.push_back(r);
		work_budget += ((c == gda_pkg::CMD_DAYS || c == gda_pkg::CMD_MONTHS) ? n : 0) + 16;
	endtask

	task automatic queue_random_req();
		logic [1:0] c;
		int unsigned d, m, y, n, pick;
		pick = $urandom_range(0, 99);
		d = $urandom_range(1, 31);
		m = $urandom_range(1, 12);
		y = $urandom_range(0, gda_pkg::YEAR_MAX);
		n = $urandom_range(0, 40);
		if (pick < 35) begin
			c = gda_pkg::CMD_DAYS;
			if ($urandom_range(0, 149) == 0) begin
				n = $urandom_range(0, (1 << gda_pkg::COUNT_W) - 1);
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(0, 400);
			end
		end else if (pick < 60) begin
			c = gda_pkg::CMD_MONTHS;
			if ($urandom_range(0, 149) == 0) begin
				n = $urandom_range(0, (1 << gda_pkg::COUNT_W) - 1);
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(0, 400);
			end
		end else if (pick < 88) begin
			c = gda_pkg::CMD_YEARS;
			n = $urandom_range(0, (1 << gda_pkg::COUNT_W) - 1);
		end else begin
			c = (pick < 96) ? 2'($urandom) : CMD_NONE;
			n = $urandom_range(0, (1 << gda_pkg::COUNT_W) - 1);
			if ($urandom_range(0, 1) == 0) begin
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end else if ($urandom_range(0, 1) == 0) begin
				d = 0;
			end else begin
				m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
			end
		end
		if (pick < 88) begin
			case ($urandom_range(0, 9))
				0: begin
					y = gda_pkg::YEAR_MAX - $urandom_range(0, 1);
					if ($urandom_range(0, 1) == 0) begin
						m = gda_pkg::MONTH_DEC;
					end
				end
				1: begin
					y = 100 * $urandom_range(0, 327);
					m = gda_pkg::MONTH_FEB;
					d = $urandom_range(27, 29);
				end
				2: begin
					y = 4 * $urandom_range(0, 8191);
					m = gda_pkg::MONTH_FEB;
				end
				3: begin
					m = gda_pkg::MONTH_DEC;
					d = gda_pkg::DAY_LAST - $urandom_range(0, 3);
				end
				default: begin
				end
			endcase
		end
		queue_req(c, d, m, y, n);
	endtask

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		if (err_count < 50) begin
			$display("mismatch at result %0d on %s: got %0d, expected %0d",
				beats_out, what, got, want);
		end
		err_count++;
	endtask

	// driver
	always @(posedge clk) begin
		logic next_valid;
		date_res_t pred;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pred = advance_date(cur_req);
				expected_dates.push_back(pred);
				cmd_beats[cur_req.cmd]++;
				if (pred.status == gda_pkg::STAT_BAD_DATE) begin
					bad_dates++;
				end
				if (pred.status == gda_pkg::STAT_OVERFLOW) begin
					overflows++;
				end
				next_valid = 1'b0;
				if ($urandom_range(0, 99) == 0) begin
					send_burst = !send_burst;
				end
				send_gap = send_burst ? 0 : $urandom_range(0, 3);
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					cmd <= cur_req.cmd;
					day_in <= cur_req.day;
					month_in <= cur_req.month;
					year_in <= cur_req.year;
					count <= cur_req.count;
					next_valid = 1'b1;
				end
			end
		end
		in_valid <= next_valid;
	end

	// monitor
	always @(posedge clk) begin
		date_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					flag_mismatch("unexpected beat", 1, 0);
				end else begin
					want = expected_dates.pop_front();
					if (day_out !== want.day) begin
						flag_mismatch("day_out", day_out, want.day);
					end
					if (month_out !== want.month) begin
						flag_mismatch("month_out", month_out, want.month);
					end
					if (year_out !== want.year) begin
						flag_mismatch("year_out", year_out, want.year);
					end
					if (status !== want.status) begin
						flag_mismatch("status", status, want.status);
					end
				end
				beats_out <= beats_out + 1;
				if ($urandom_range(0, 99) == 0) begin
					recv_burst = !recv_burst;
				end
				recv_gap = recv_burst ? 0 : $urandom_range(0, 3);
			end else if (recv_gap != 0) begin
				recv_gap--;
			end
			out_ready <= (hold_left == 0) && (recv_gap == 0);
		end
	end

	// long receiver stall so the block backs up into its input
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_out >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > cycle_limit) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_dates.size());
			$display("gregorian_date_adder_unit_test: FAIL");
			$finish;
		end
	end

	initial begin
		queue_req(gda_pkg::CMD_DAYS, 1, 1, 0, 0);
		queue_req(gda_pkg::CMD_DAYS, 28, 2, 2000, 1);
		queue_req(gda_pkg::CMD_DAYS, 28, 2, 1900, 1);
		queue_req(gda_pkg::CMD_DAYS, 28, 2, 2024, 2);
		queue_req(gda_pkg::CMD_DAYS, 31, 12, 1999, 1);
		queue_req(gda_pkg::CMD_DAYS, 31, 4, 2010, 0);
		queue_req(gda_pkg::CMD_DAYS, 31, 4, 2010, 1);
		queue_req(gda_pkg::CMD_DAYS, 31, 2, 2023, 1);
		queue_req(gda_pkg::CMD_DAYS, 25, 12, gda_pkg::YEAR_MAX, 10);
		queue_req(gda_pkg::CMD_DAYS, 31, 12, gda_pkg::YEAR_MAX, 0);
		queue_req(gda_pkg::CMD_DAYS, 1, 1, 0, (1 << gda_pkg::COUNT_W) - 1);
		queue_req(gda_pkg::CMD_MONTHS, 15, 12, 2023, 1);
		queue_req(gda_pkg::CMD_MONTHS, 31, 1, 2021, 1);
		queue_req(gda_pkg::CMD_MONTHS, 9, 11, gda_pkg::YEAR_MAX, 2);
		queue_req(gda_pkg::CMD_MONTHS, 1, 1, 0, (1 << gda_pkg::COUNT_W) - 1);
		queue_req(gda_pkg::CMD_MONTHS, 30, 12, 500, 0);
		queue_req(gda_pkg::CMD_YEARS, 1, 1, 0, (1 << gda_pkg::COUNT_W) - 1);
		queue_req(gda_pkg::CMD_YEARS, 29, 2, 1, (1 << gda_pkg::COUNT_W) - 1);
		queue_req(gda_pkg::CMD_YEARS, 31, 12, gda_pkg::YEAR_MAX, 0);
		queue_req(gda_pkg::CMD_DAYS, 10, 0, 2000, 5);
		queue_req(gda_pkg::CMD_MONTHS, 10, 13, 2000, 5);
		queue_req(gda_pkg::CMD_YEARS, 10, 15, 2000, 5);
		queue_req(gda_pkg::CMD_DAYS, 0, 6, 2000, 5);
		queue_req(CMD_NONE, 31, 12, gda_pkg::YEAR_MAX, (1 << gda_pkg::COUNT_W) - 1);
		queue_req(CMD_NONE, 31, 15, gda_pkg::YEAR_MAX, (1 << gda_pkg::COUNT_W) - 1);
		repeat (RANDOM_ITEMS) begin
			queue_random_req();
		end
		total_items = pending_reqs.size();
		cycle_limit = 4 * (work_budget + HOLD_CYCLES) + 20000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (beats_out < total_items) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("beats checked: %0d (days %0d, months %0d, years %0d, unused cmd %0d)",
			beats_out, cmd_beats[gda_pkg::CMD_DAYS], cmd_beats[gda_pkg::CMD_MONTHS],
			cmd_beats[gda_pkg::CMD_YEARS], cmd_beats[CMD_NONE]);
		$display("bad input dates %0d, saturated years %0d, mismatches %0d",
			bad_dates, overflows, err_count);
		if (err_count == 0) begin
			$display("gregorian_date_adder_unit_test: PASS");
		end else begin
			$display("gregorian_date_adder_unit_test: FAIL");
		end
		$finish;
	end

endmodule
